// ===== sv/qprot_pkg.sv =====
package qprot_pkg;

  // data format
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  // multiplier operands carry one extra bit so a negated minimum value stays exact
  localparam int OPD_W      = DATA_WIDTH + 1;
  localparam int PROD_W     = 2 * OPD_W;
  // four products plus the rounding half
  localparam int SUM_W      = PROD_W + 3;
  localparam int NUM_COMP   = 4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [OPD_W-1:0]      opd_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // components in x, y, z, w order
  typedef data_t [NUM_COMP-1:0] quat_t;
  typedef opd_t  [NUM_COMP-1:0] opd_quat_t;

  typedef enum logic [2:0] {
    CMD_PROD = 3'd0,
    CMD_ROT  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_CONJ = 3'd4
  } cmd_e;

  localparam int COMP_W = 3;

  // saturated value and its flag
  typedef struct packed {
    data_t val;
    logic  sat;
  } sat_res_t;

  // fields that travel beside the multiplier pipeline
  typedef struct packed {
    cmd_e  cmd;
    quat_t simple;
    logic  simple_ovf;
  } side_t;

  // hamilton product terms: row k is result component k, column m one term
  localparam logic [1:0] TERM_A [NUM_COMP][NUM_COMP] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [1:0] TERM_B [NUM_COMP][NUM_COMP] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  // bit m set: term m is subtracted
  localparam logic [NUM_COMP-1:0] TERM_NEG [NUM_COMP] = '{
    4'b1000,
    4'b0010,
    4'b0100,
    4'b1110
  };

  localparam sum_t DATA_MAX_S = (sum_t'(1) <<< (DATA_WIDTH - 1)) - sum_t'(1);
  localparam sum_t DATA_MIN_S = -DATA_MAX_S - sum_t'(1);
  localparam sum_t RND_HALF   = sum_t'(1) <<< (FRAC_BITS - 1);

  function automatic opd_t to_opd(data_t d);
    return {d[DATA_WIDTH-1], d};
  endfunction

  function automatic sum_t to_sum(data_t d);
    return {{(SUM_W - DATA_WIDTH){d[DATA_WIDTH-1]}}, d};
  endfunction

  // clamp a wide value into the data range
  function automatic sat_res_t sat_data(sum_t v);
    sat_res_t r;
    if (v > DATA_MAX_S) begin
      r.val = DATA_MAX_S[DATA_WIDTH-1:0];
      r.sat = 1'b1;
    end else if (v < DATA_MIN_S) begin
      r.val = DATA_MIN_S[DATA_WIDTH-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic sat_res_t round_sat(sum_t acc);
    sum_t rnd;
    rnd = acc + RND_HALF;
    return sat_data(rnd >>> FRAC_BITS);
  endfunction

endpackage

// ===== sv/qprot_if.sv =====
interface qprot_in_if import qprot_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  data_t      a_x;
  data_t      a_y;
  data_t      a_z;
  data_t      a_w;
  data_t      b_x;
  data_t      b_y;
  data_t      b_z;
  data_t      b_w;

  modport source (
    output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    input  ready
  );
  modport sink (
    input  valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    output ready
  );
endinterface

interface qprot_out_if import qprot_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t res_x;
  data_t res_y;
  data_t res_z;
  data_t res_w;
  logic  overflow;

  modport source (
    output valid, res_x, res_y, res_z, res_w, overflow,
    input  ready
  );
  modport sink (
    input  valid, res_x, res_y, res_z, res_w, overflow,
    output ready
  );
endinterface

// ===== sv/quaternion_product_rotate_unit.sv =====
// Fixed-point quaternion unit, Q2.14. Each request gives one result: the
// Hamilton product A*B, the rotation of vector (b_x, b_y, b_z) by A (res_w
// reads 0), component-wise add or subtract, or the conjugate of A; unused
// command codes return zero. Every product sum is exact, rounded once to
// nearest with ties upward and saturated; overflow flags any saturation,
// including the intermediate A*v of a rotation. The unit takes one request
// per clock while no output stall holds it, through four register stages:
// two product arrays of sixteen 17x17 multipliers, each a multiply stage
// and a sum-round-saturate stage, run back to back. A result is shown once
// its request reaches the fourth stage; a stage holds only while it is full
// and the stage after it cannot move, so empty stages close up behind an
// output stall.
module quaternion_product_rotate_unit import qprot_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  qprot_in_if.sink    in_i,
  qprot_out_if.source out_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  side_t side_d, side1_q, side2_q, side3_q, side4_q;
  quat_t a_in, b_in, a1_q, a2_q, t3_q, t4_q;
  logic [NUM_COMP-1:0] t3_sat_q, t4_sat_q;
  cmd_e  cmd_in;

  opd_quat_t mul0_a, mul0_b, mul1_a, mul1_b;
  quat_t     mul0_res, mul1_res;
  logic [NUM_COMP-1:0] mul0_sat, mul1_sat;

  quat_t res;
  logic  res_ovf;

  // stage advance: a stage moves when empty or when the next one moves
  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // request unpacking
  assign cmd_in = cmd_e'(in_i.cmd);
  assign a_in   = {in_i.a_w, in_i.a_z, in_i.a_y, in_i.a_x};
  assign b_in   = {in_i.b_w, in_i.b_z, in_i.b_y, in_i.b_x};

  // add, subtract and conjugate are done at the input
  always_comb begin
    sat_res_t r;
    side_d.cmd        = cmd_in;
    side_d.simple     = '0;
    side_d.simple_ovf = 1'b0;
    unique case (cmd_in)
      CMD_ADD: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          r = sat_data(to_sum(a_in[i]) + to_sum(b_in[i]));
          side_d.simple[i] = r.val;
          side_d.simple_ovf = side_d.simple_ovf | r.sat;
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          r = sat_data(to_sum(a_in[i]) - to_sum(b_in[i]));
          side_d.simple[i] = r.val;
          side_d.simple_ovf = side_d.simple_ovf | r.sat;
        end
      end
      CMD_CONJ: begin
        for (int i = 0; i < COMP_W; i++) begin
          r = sat_data(-to_sum(a_in[i]));
          side_d.simple[i] = r.val;
          side_d.simple_ovf = side_d.simple_ovf | r.sat;
        end
        side_d.simple[COMP_W] = a_in[COMP_W];
      end
      default: begin
        side_d.simple     = '0;
        side_d.simple_ovf = 1'b0;
      end
    endcase
  end

  // first product operands: vector has zero scalar for rotate
  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      mul0_a[i] = to_opd(a_in[i]);
      mul0_b[i] = to_opd(b_in[i]);
    end
    if (cmd_in == CMD_ROT) begin
      mul0_b[COMP_W] = '0;
    end
  end

  qprot_hprod u_mul0 (
    .clk_i    (clk_i),
    .a_i      (mul0_a),
    .b_i      (mul0_b),
    .mul_en_i (rdy1),
    .sum_en_i (rdy2),
    .res_o    (mul0_res),
    .sat_o    (mul0_sat)
  );

  // side data pipeline
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      side1_q <= side_d;
      a1_q    <= a_in;
    end
    if (rdy2) begin
      side2_q <= side1_q;
      a2_q    <= a1_q;
    end
    if (rdy3) begin
      side3_q  <= side2_q;
      t3_q     <= mul0_res;
      t3_sat_q <= mul0_sat;
    end
    if (rdy4) begin
      side4_q  <= side3_q;
      t4_q     <= t3_q;
      t4_sat_q <= t3_sat_q;
    end
  end

  // second product: intermediate times exact conjugate of A
  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      mul1_a[i] = to_opd(mul0_res[i]);
      mul1_b[i] = (i < COMP_W) ? -to_opd(a2_q[i]) : to_opd(a2_q[i]);
    end
  end

  qprot_hprod u_mul1 (
    .clk_i    (clk_i),
    .a_i      (mul1_a),
    .b_i      (mul1_b),
    .mul_en_i (rdy3),
    .sum_en_i (rdy4),
    .res_o    (mul1_res),
    .sat_o    (mul1_sat)
  );

  // result select
  always_comb begin
    case (side4_q.cmd)
      CMD_PROD: begin
        res     = t4_q;
        res_ovf = |t4_sat_q;
      end
      CMD_ROT: begin
        res         = mul1_res;
        res[COMP_W] = '0;
        res_ovf     = (|t4_sat_q) | (|mul1_sat[COMP_W-1:0]);
      end
      default: begin
        res     = side4_q.simple;
        res_ovf = side4_q.simple_ovf;
      end
    endcase
  end

  assign out_o.valid    = v4_q;
  assign out_o.res_x    = res[0];
  assign out_o.res_y    = res[1];
  assign out_o.res_z    = res[2];
  assign out_o.res_w    = res[COMP_W];
  assign out_o.overflow = res_ovf;

  // accepted request lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted request missing from first stage");

  // a taken result with nothing behind it is not shown again
  a_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !v3_q |=> !out_o.valid)
    else $error("result repeated");

  // rotation reports zero scalar
  a_rot_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && side4_q.cmd == CMD_ROT |-> out_o.res_w == '0)
    else $error("rotate result has nonzero scalar");

endmodule

// ===== sv/qprot_hprod.sv =====
module qprot_hprod import qprot_pkg::*; (
  input  logic             clk_i,
  input  opd_quat_t        a_i,
  input  opd_quat_t        b_i,
  input  logic             mul_en_i,
  input  logic             sum_en_i,
  output quat_t            res_o,
  output logic [NUM_COMP-1:0] sat_o
);

  prod_t           prod_q [NUM_COMP][NUM_COMP];
  sat_res_t        comp_res [NUM_COMP];
  quat_t           res_q;
  logic [NUM_COMP-1:0] sat_q;

  // product stage: sixteen signed multiplies
  for (genvar k = 0; k < NUM_COMP; k++) begin : g_row
    for (genvar m = 0; m < NUM_COMP; m++) begin : g_term
      always_ff @(posedge clk_i) begin
        if (mul_en_i) begin
          prod_q[k][m] <= $signed(a_i[TERM_A[k][m]]) * $signed(b_i[TERM_B[k][m]]);
        end
      end
    end
  end

  // sum stage: exact sum of four terms, one rounding, saturation
  always_comb begin
    sum_t acc;
    sum_t ext;
    for (int k = 0; k < NUM_COMP; k++) begin
      acc = '0;
      for (int m = 0; m < NUM_COMP; m++) begin
        ext = sum_t'(prod_q[k][m]);
        if (TERM_NEG[k][m]) begin
          acc = acc - ext;
        end else begin
          acc = acc + ext;
        end
      end
      comp_res[k] = round_sat(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        res_q[k] <= comp_res[k].val;
        sat_q[k] <= comp_res[k].sat;
      end
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
